>>> rtl/motor_feedback_multiturn_decoder_defines.svh
`ifndef MOTOR_FEEDBACK_MULTITURN_DECODER_DEFINES_SVH
`define MOTOR_FEEDBACK_MULTITURN_DECODER_DEFINES_SVH

// same-cycle implication, sampled on clk, off during rst
`define MFMD_ASSERT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define MFMD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/mfmd_pkg.sv
`default_nettype none

package mfmd_pkg;

  localparam int NUM_MOTORS_DEF = 4;

  localparam int ID_W   = 11;
  localparam int PL_W   = 64;
  localparam int WORD_W = 16;
  localparam int TEMP_W = 8;
  localparam int TURN_W = 24;
  localparam int POS_W  = 41;
  localparam int FRAC_W = 20;

  localparam int MID_DEPTH = 2;
  localparam int OUT_DEPTH = 4;

  localparam logic [ID_W-1:0] BASE_ID_RST = 11'd513;

  localparam logic signed [TURN_W-1:0] TURN_MAX = 24'sd8388607;
  localparam logic signed [TURN_W-1:0] TURN_MIN = -24'sd8388607;
  localparam logic signed [WORD_W:0]   HALF_REV = 17'sd4096;

  typedef struct packed {
    logic [WORD_W-1:0] angle;
    logic [WORD_W-1:0] speed_raw;
    logic [WORD_W-1:0] current_raw;
    logic [TEMP_W-1:0] temperature;
  } fields_t;

  typedef struct packed {
    logic [1:0]               motor_index;
    fields_t                  fields;
    logic signed [TURN_W-1:0] turns;
    logic signed [POS_W-1:0]  position;
  } result_t;

  // floor(ang * 65536 / 8191) = 8*ang + floor(8*ang / 8191).
  // With y = 8*ang = 8192*q0 + r0, y = 8191*q0 + (q0 + r0), and q0 + r0 < 2*8191,
  // so one compare fixes the quotient.
  function automatic logic [FRAC_W-1:0] frac_of(input logic [WORD_W-1:0] ang);
    logic [13:0] rem;
    logic        q_inc;
    rem   = {1'b0, ang[9:0], 3'b000} + {8'b0, ang[15:10]};
    q_inc = (rem >= 14'd8191);
    return {1'b0, ang, 3'b000} + {14'b0, ang[15:10]} + {19'b0, q_inc};
  endfunction

endpackage

`default_nettype wire

>>> rtl/motor_feedback_multiturn_decoder.sv
// An accepted item passes the input register, the item queue, the per-motor update stage
// and the result queue, in that order, before it reaches the result ports.
// Throughput: one item per cycle while no queue backs up; the read-modify-write of angle and
// turns lands at the take edge, so back-to-back items for one motor run at full rate.
// Frames whose identifier misses the motor window are dropped in the front and give no result.
// Reset (synchronous, rst high): queues emptied, base_id = 513, stored angles and turns = 0.
`default_nettype none

module motor_feedback_multiturn_decoder
  import mfmd_pkg::*;
#(
  parameter int NUM_MOTORS = NUM_MOTORS_DEF
) (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     push,
  output logic                          full,
  input  wire logic        [ID_W-1:0]   frame_id,
  input  wire logic        [PL_W-1:0]   payload,
  input  wire logic                     pop,
  output logic                          empty,
  output logic             [1:0]        motor_index,
  output logic             [WORD_W-1:0] angle,
  output logic             [WORD_W-1:0] speed_raw,
  output logic             [WORD_W-1:0] current_raw,
  output logic             [TEMP_W-1:0] temperature,
  output logic signed      [TURN_W-1:0] turns,
  output logic signed      [POS_W-1:0]  position,
  input  wire logic                     cfg_valid,
  output logic                          cfg_ready,
  input  wire logic        [ID_W-1:0]   cfg_data
);

  localparam int IDX_W = (NUM_MOTORS > 1) ? $clog2(NUM_MOTORS) : 1;
  localparam int ITEM_W = $bits(fields_t) + IDX_W;

  logic [ID_W-1:0]  base_id;
  logic             q_wr;
  fields_t          q_wr_fields;
  logic [IDX_W-1:0] q_wr_idx;
  logic             q_full;
  logic             q_rd;
  logic             q_empty;
  logic [ITEM_W-1:0] q_rd_data;
  result_t          res;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      base_id <= BASE_ID_RST;
    end else if (cfg_valid && cfg_ready) begin
      base_id <= cfg_data;
    end
  end

  mfmd_front #(
    .NUM_MOTORS(NUM_MOTORS),
    .IDX_W     (IDX_W)
  ) u_front (
    .clk     (clk),
    .rst     (rst),
    .base_id (base_id),
    .push    (push),
    .full    (full),
    .frame_id(frame_id),
    .payload (payload),
    .q_wr    (q_wr),
    .q_fields(q_wr_fields),
    .q_idx   (q_wr_idx),
    .q_full  (q_full)
  );

  mfmd_queue #(
    .WIDTH(ITEM_W),
    .DEPTH(MID_DEPTH)
  ) u_mid_queue (
    .clk    (clk),
    .rst    (rst),
    .wr_en  (q_wr),
    .wr_data({q_wr_idx, q_wr_fields}),
    .full   (q_full),
    .rd_en  (q_rd),
    .rd_data(q_rd_data),
    .empty  (q_empty),
    .count  ()
  );

  mfmd_back #(
    .NUM_MOTORS(NUM_MOTORS),
    .IDX_W     (IDX_W)
  ) u_back (
    .clk     (clk),
    .rst     (rst),
    .q_empty (q_empty),
    .q_rd    (q_rd),
    .q_fields(q_rd_data[$bits(fields_t)-1:0]),
    .q_idx   (q_rd_data[ITEM_W-1:$bits(fields_t)]),
    .pop     (pop),
    .empty   (empty),
    .res     (res)
  );

  assign motor_index = res.motor_index;
  assign angle       = res.fields.angle;
  assign speed_raw   = res.fields.speed_raw;
  assign current_raw = res.fields.current_raw;
  assign temperature = res.fields.temperature;
  assign turns       = res.turns;
  assign position    = res.position;

endmodule

`default_nettype wire

>>> rtl/mfmd_queue.sv
`default_nettype none

module mfmd_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2,
  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  localparam int CNT_W = $clog2(DEPTH + 1)
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             wr_en,
  input  wire logic [WIDTH-1:0] wr_data,
  output logic                  full,
  input  wire logic             rd_en,
  output logic      [WIDTH-1:0] rd_data,
  output logic                  empty,
  output logic      [CNT_W-1:0] count
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic             do_wr;
  logic             do_rd;

  assign full    = (count == CNT_W'(DEPTH));
  assign empty   = (count == '0);
  assign do_wr   = wr_en && !full;
  assign do_rd   = rd_en && !empty;
  assign rd_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_rd) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({do_wr, do_rd})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

`default_nettype wire

>>> rtl/mfmd_front.sv
`default_nettype none

module mfmd_front
  import mfmd_pkg::*;
#(
  parameter int NUM_MOTORS = NUM_MOTORS_DEF,
  parameter int IDX_W      = 2
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic [ID_W-1:0]  base_id,
  input  wire logic             push,
  output logic                  full,
  input  wire logic [ID_W-1:0]  frame_id,
  input  wire logic [PL_W-1:0]  payload,
  output logic                  q_wr,
  output fields_t               q_fields,
  output logic      [IDX_W-1:0] q_idx,
  input  wire logic             q_full
);

  logic             f_valid;
  fields_t          f_fields;
  logic [IDX_W-1:0] f_idx;
  logic             ready;
  logic [ID_W:0]    id_diff;
  logic             match;

  // frames below base_id show up as a borrow
  assign id_diff = {1'b0, frame_id} - {1'b0, base_id};
  assign match   = !id_diff[ID_W] && (id_diff[ID_W-1:0] < ID_W'(NUM_MOTORS));

  assign ready = !f_valid || !q_full;
  assign full  = !ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      f_valid <= 1'b0;
    end else if (ready) begin
      f_valid <= push && match;
    end
  end

  always_ff @(posedge clk) begin
    if (ready && push) begin
      f_idx                <= id_diff[IDX_W-1:0];
      f_fields.angle       <= payload[63:48];
      f_fields.speed_raw   <= payload[47:32];
      f_fields.current_raw <= payload[31:16];
      f_fields.temperature <= payload[15:8];
    end
  end

  assign q_wr     = f_valid && !q_full;
  assign q_fields = f_fields;
  assign q_idx    = f_idx;

endmodule

`default_nettype wire

>>> rtl/mfmd_back.sv
`default_nettype none
`include "motor_feedback_multiturn_decoder_defines.svh"

module mfmd_back
  import mfmd_pkg::*;
#(
  parameter int NUM_MOTORS = NUM_MOTORS_DEF,
  parameter int IDX_W      = 2
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             q_empty,
  output logic                  q_rd,
  input  wire fields_t          q_fields,
  input  wire logic [IDX_W-1:0] q_idx,
  input  wire logic             pop,
  output logic                  empty,
  output result_t               res
);

  localparam int CNT_W = $clog2(OUT_DEPTH + 1);

  logic        [WORD_W-1:0] last_angle [NUM_MOTORS];
  logic signed [TURN_W-1:0] turn_count [NUM_MOTORS];

  logic                     take;
  logic        [CNT_W-1:0]  out_count;
  logic        [CNT_W:0]    in_flight;
  logic                     out_full;
  logic                     out_push;
  result_t                  out_data;

  logic        [WORD_W-1:0] prev_angle;
  logic signed [TURN_W-1:0] prev_turns;
  logic signed [WORD_W:0]   delta;
  logic signed [TURN_W-1:0] turns_next;
  logic        [IDX_W+1:0]  idx_ext;

  logic                     s1_valid;
  logic        [1:0]        s1_index;
  fields_t                  s1_fields;
  logic signed [TURN_W-1:0] s1_turns;
  logic        [FRAC_W-1:0] s1_frac;
  logic        [POS_W-17:0] pos_gap;

  // only take an item when the result queue has room for it and the one in s1
  assign in_flight = {1'b0, out_count} + {{CNT_W{1'b0}}, s1_valid};
  assign take      = !q_empty && (in_flight < (CNT_W + 1)'(OUT_DEPTH));
  assign q_rd      = take;

  assign prev_angle = last_angle[q_idx];
  assign prev_turns = turn_count[q_idx];
  assign delta      = $signed({1'b0, q_fields.angle}) - $signed({1'b0, prev_angle});

  always_comb begin
    turns_next = prev_turns;
    if (delta < -HALF_REV && prev_turns < TURN_MAX) begin
      turns_next = prev_turns + 24'sd1;
    end
    if (delta > HALF_REV && prev_turns > TURN_MIN) begin
      turns_next = prev_turns - 24'sd1;
    end
  end

  assign idx_ext = {2'b00, q_idx};

  // per-motor read-modify-write lands at this edge, so a following item
  // for the same motor sees the new state
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      for (int k = 0; k < NUM_MOTORS; k++) begin
        last_angle[k] <= '0;
        turn_count[k] <= '0;
      end
    end else begin
      s1_valid <= take;
      if (take) begin
        last_angle[q_idx] <= q_fields.angle;
        turn_count[q_idx] <= turns_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      s1_index  <= idx_ext[1:0];
      s1_fields <= q_fields;
      s1_turns  <= turns_next;
      s1_frac   <= frac_of(q_fields.angle);
    end
  end

  assign out_push             = s1_valid;
  assign out_data.motor_index = s1_index;
  assign out_data.fields      = s1_fields;
  assign out_data.turns       = s1_turns;
  assign out_data.position    = $signed({s1_turns[TURN_W-1], s1_turns, 16'b0})
                              + $signed({{(POS_W-FRAC_W){1'b0}}, s1_frac});

  assign pos_gap = out_data.position[POS_W-1:16] - {s1_turns[TURN_W-1], s1_turns};

  mfmd_queue #(
    .WIDTH($bits(result_t)),
    .DEPTH(OUT_DEPTH)
  ) u_out_queue (
    .clk    (clk),
    .rst    (rst),
    .wr_en  (out_push),
    .wr_data(out_data),
    .full   (out_full),
    .rd_en  (pop),
    .rd_data(res),
    .empty  (empty),
    .count  (out_count)
  );

  `MFMD_ASSERT(a_out_room, s1_valid, !out_full, "result queue overflow")
  `MFMD_ASSERT(a_turn_floor, s1_valid, s1_turns >= TURN_MIN, "turn count below limit")
  `MFMD_ASSERT(a_pos_int, s1_valid, pos_gap <= 25'd8, "position integer part off turns")
  `MFMD_ASSERT_NEXT(a_take_lands, take, s1_valid, "taken item missing in s1")

endmodule

`default_nettype wire
